// ===== hdl/face_backface_cull_defines.svh =====
// Assertion macros used by the face culling sequencer.
`ifndef FACE_BACKFACE_CULL_DEFINES_SVH
`define FACE_BACKFACE_CULL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/fbc_pkg.sv =====
// Shared types, constants and helpers of the face culling block.
package fbc_pkg;

  localparam int unsigned MaxFaceVertices = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned WorldW = 24;
  localparam int unsigned SumW = 30;
  localparam int unsigned RegW = 64;
  localparam int unsigned CamW = 48;
  localparam int unsigned AddrW = 6;

  localparam logic [2:0] RegRowX = 3'd0;
  localparam logic [2:0] RegRowY = 3'd1;
  localparam logic [2:0] RegRowZ = 3'd2;
  localparam logic [2:0] RegCam = 3'd3;
  localparam logic [2:0] RegMode = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_WMUL,
    OP_WB,
    OP_EDGE,
    OP_NMUL_P,
    OP_NMUL_M,
    OP_NWB,
    OP_VMUL,
    OP_VSUB,
    OP_VWB,
    OP_DLO,
    OP_DHI,
    OP_DECIDE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic [1:0] col;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
  } stat_t;

  typedef struct packed {
    logic [2:0][RegW-1:0] rows;
    logic [CamW-1:0]      cam;
    logic                 persp;
  } cfg_t;

  function automatic logic [1:0] next3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

// ===== hdl/fbc_if.sv =====
// Request channel interfaces for vertices in and verdicts out.
interface fbc_vtx_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fbc_pkg::CoordW-1:0]    vertex_x;
  logic signed [fbc_pkg::CoordW-1:0]    vertex_y;
  logic signed [fbc_pkg::CoordW-1:0]    vertex_z;
  logic                                 last_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface fbc_res_if;
  logic valid;
  logic ready;
  logic front_facing;
  logic face_too_long;
  modport source (output valid, front_facing, face_too_long, input ready);
  modport sink (input valid, front_facing, face_too_long, output ready);
endinterface

// ===== hdl/fbc_regs.sv =====
// APB configuration registers of the face culling block.
module fbc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbc_pkg::AddrW-1:0]  paddr,
  input  logic [fbc_pkg::RegW-1:0]   pwdata,
  output logic [fbc_pkg::RegW-1:0]   prdata,
  output logic                       pready,
  output fbc_pkg::cfg_t              cfg_o
);

  fbc_pkg::cfg_t cfg_q;
  logic [2:0]    idx;

  assign idx    = paddr[fbc_pkg::AddrW-1:3];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows[0] <= fbc_pkg::RegW'(64'd4096);
      cfg_q.rows[1] <= fbc_pkg::RegW'(64'd4096 << 16);
      cfg_q.rows[2] <= fbc_pkg::RegW'(64'd4096 << 32);
      cfg_q.cam     <= '0;
      cfg_q.persp   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        fbc_pkg::RegRowX: cfg_q.rows[0] <= pwdata;
        fbc_pkg::RegRowY: cfg_q.rows[1] <= pwdata;
        fbc_pkg::RegRowZ: cfg_q.rows[2] <= pwdata;
        fbc_pkg::RegCam:  cfg_q.cam <= pwdata[fbc_pkg::CamW-1:0];
        fbc_pkg::RegMode: cfg_q.persp <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fbc_pkg::RegRowX: prdata = cfg_q.rows[0];
      fbc_pkg::RegRowY: prdata = cfg_q.rows[1];
      fbc_pkg::RegRowZ: prdata = cfg_q.rows[2];
      fbc_pkg::RegCam:  prdata = fbc_pkg::RegW'(cfg_q.cam);
      fbc_pkg::RegMode: prdata = fbc_pkg::RegW'(cfg_q.persp);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/fbc_ctrl.sv =====
// Sequencer that steps the datapath through vertex and face programs.
`include "face_backface_cull_defines.svh"

module fbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fbc_pkg::stat_t stat_i,
  output fbc_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VERT,
    ST_EDGE,
    ST_NORM,
    ST_VIEW,
    ST_DOT,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  state_e     state_q;
  logic [1:0] grp_q;
  logic [2:0] ph_q;
  logic       out_valid_q;
  logic       accept;
  logic       fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.op  = fbc_pkg::OP_NOP;
    cmd_o.sel = grp_q;
    cmd_o.col = ph_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) cmd_o.op = fbc_pkg::OP_LOAD;
      end
      ST_VERT: begin
        if (ph_q < 3'd3) cmd_o.op = fbc_pkg::OP_WMUL;
        else if (ph_q == 3'd4) cmd_o.op = fbc_pkg::OP_WB;
      end
      ST_EDGE: cmd_o.op = fbc_pkg::OP_EDGE;
      ST_NORM: begin
        if (ph_q == 3'd0) cmd_o.op = fbc_pkg::OP_NMUL_P;
        else if (ph_q == 3'd1) cmd_o.op = fbc_pkg::OP_NMUL_M;
        else if (ph_q == 3'd3) cmd_o.op = fbc_pkg::OP_NWB;
      end
      ST_VIEW: begin
        if (ph_q == 3'd0) cmd_o.op = fbc_pkg::OP_VMUL;
        else if (ph_q == 3'd1) cmd_o.op = fbc_pkg::OP_VSUB;
        else if (ph_q == 3'd3) cmd_o.op = fbc_pkg::OP_VWB;
      end
      ST_DOT: cmd_o.op = ph_q[0] ? fbc_pkg::OP_DHI : fbc_pkg::OP_DLO;
      ST_DRAIN: ;
      ST_DECIDE: begin
        if (fire) cmd_o.op = fbc_pkg::OP_DECIDE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          grp_q <= '0;
          ph_q  <= '0;
          if (accept) begin
            if (!stat_i.full) state_q <= ST_VERT;
            else if (in_last_i) state_q <= ST_EDGE;
          end
        end
        ST_VERT: begin
          if (ph_q == 3'd4) begin
            ph_q <= '0;
            if (grp_q == 2'd2) begin
              grp_q   <= '0;
              state_q <= stat_i.last ? ST_EDGE : ST_IDLE;
            end else begin
              grp_q <= grp_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_EDGE: begin
          grp_q   <= '0;
          ph_q    <= '0;
          state_q <= ST_NORM;
        end
        ST_NORM, ST_VIEW: begin
          if (ph_q == 3'd3) begin
            ph_q <= '0;
            if (grp_q == 2'd2) begin
              grp_q   <= '0;
              state_q <= (state_q == ST_NORM) ? ST_VIEW : ST_DOT;
            end else begin
              grp_q <= grp_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_DOT: begin
          if (ph_q[0]) begin
            ph_q <= '0;
            if (grp_q == 2'd2) begin
              grp_q   <= '0;
              state_q <= ST_DRAIN;
            end else begin
              grp_q <= grp_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        ST_DRAIN: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (fire) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `FBC_ASSERT_IMP(a_decide_slot_free, clk_i, rst_ni, cmd_o.op == fbc_pkg::OP_DECIDE, !out_valid_q || out_ready_i)
  `FBC_ASSERT_NXT(a_valid_from_decide, clk_i, rst_ni, !out_valid_q && cmd_o.op != fbc_pkg::OP_DECIDE, !out_valid_q)
  `FBC_ASSERT_NXT(a_ignored_vertex, clk_i, rst_ni, accept && stat_i.full && !in_last_i, state_q == ST_IDLE)

endmodule

// ===== hdl/fbc_dp.sv =====
// Datapath: shared multiplier, accumulator and face state registers.
module fbc_dp #(
  parameter int unsigned MAX_FACE_VERTICES = fbc_pkg::MaxFaceVertices
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fbc_pkg::cmd_t                    cmd_i,
  input  fbc_pkg::cfg_t                    cfg_i,
  input  logic signed [fbc_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [fbc_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [fbc_pkg::CoordW-1:0] vertex_z_i,
  input  logic                             last_vertex_i,
  output fbc_pkg::stat_t                   stat_o,
  output logic                             front_facing_o,
  output logic                             face_too_long_o
);

  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = 88;
  localparam int unsigned EdgeW = fbc_pkg::WorldW + 1;
  localparam int unsigned NormW = 2 * EdgeW + 1;
  localparam int unsigned NsW   = NormW + 2;
  localparam int unsigned ViewW = 32;
  localparam int unsigned LoW   = 26;
  localparam int unsigned RndW  = 35;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADDHI
  } acc_e;

  logic signed [fbc_pkg::CoordW-1:0] vtx_q [3];
  logic                              last_q;
  logic signed [fbc_pkg::WorldW-1:0] fw_q [3][3];
  logic [fbc_pkg::SumW-1:0]          sum_q [3];
  logic [fbc_pkg::CountW-1:0]        cnt_q;
  logic                              ovf_q;
  logic signed [EdgeW-1:0]           e1_q [3];
  logic signed [EdgeW-1:0]           e2_q [3];
  logic signed [NormW-1:0]           n_q [3];
  logic signed [ViewW-1:0]           view_q [3];
  logic signed [ProdW-1:0]           prod_q;
  acc_e                              act_q;
  logic signed [AccW-1:0]            acc_q;
  logic                              front_q;
  logic                              long_q;

  logic signed [MulW-1:0]            mul_a;
  logic signed [MulW-1:0]            mul_b;
  logic signed [ProdW-1:0]           prod_d;
  acc_e                              act_d;
  logic                              use_sum;
  logic [1:0]                        jj;
  logic [1:0]                        kk;
  logic signed [RndW-1:0]            wsum;
  logic signed [RndW-1:0]            wshift;
  logic signed [fbc_pkg::WorldW-1:0] world;
  logic signed [AccW-1:0]            prod_ext;
  logic signed [NsW-1:0]             nsum;
  logic                              full;
  logic                              front_d;

  assign full   = (cnt_q == fbc_pkg::CountW'(MAX_FACE_VERTICES));
  assign stat_o = '{full: full, last: last_q};
  assign front_facing_o  = front_q;
  assign face_too_long_o = long_q;

  always_comb begin
    jj      = fbc_pkg::next3(cmd_i.sel);
    kk      = fbc_pkg::next3(jj);
    mul_a   = '0;
    mul_b   = '0;
    act_d   = ACC_HOLD;
    use_sum = 1'b0;
    unique case (cmd_i.op)
      fbc_pkg::OP_WMUL: begin
        mul_a = MulW'($signed(cfg_i.rows[cmd_i.sel][16*cmd_i.col +: 16]));
        mul_b = MulW'(vtx_q[cmd_i.col]);
        act_d = (cmd_i.col == 2'd0) ? ACC_LOAD : ACC_ADD;
      end
      fbc_pkg::OP_NMUL_P: begin
        mul_a = MulW'(e1_q[jj]);
        mul_b = MulW'(e2_q[kk]);
        act_d = ACC_LOAD;
      end
      fbc_pkg::OP_NMUL_M: begin
        mul_a = MulW'(e1_q[kk]);
        mul_b = MulW'(e2_q[jj]);
        act_d = ACC_SUB;
      end
      fbc_pkg::OP_VMUL: begin
        mul_a = MulW'($signed({1'b0, cnt_q}));
        mul_b = MulW'($signed(cfg_i.cam[16*cmd_i.sel +: 16]));
        act_d = ACC_LOAD;
      end
      fbc_pkg::OP_VSUB: begin
        use_sum = 1'b1;
        act_d   = ACC_SUB;
      end
      fbc_pkg::OP_DLO: begin
        mul_a = MulW'($signed({1'b0, n_q[cmd_i.sel][LoW-1:0]}));
        mul_b = MulW'(view_q[cmd_i.sel]);
        act_d = (cmd_i.sel == 2'd0) ? ACC_LOAD : ACC_ADD;
      end
      fbc_pkg::OP_DHI: begin
        mul_a = MulW'($signed(n_q[cmd_i.sel][NormW-1:LoW]));
        mul_b = MulW'(view_q[cmd_i.sel]);
        act_d = ACC_ADDHI;
      end
      default: ;
    endcase
    prod_d = use_sum ? ProdW'($signed(sum_q[cmd_i.sel])) : mul_a * mul_b;

    prod_ext = AccW'(prod_q);
    wsum     = $signed(acc_q[RndW-1:0]) + RndW'(2048);
    wshift   = wsum >>> 12;
    world    = fbc_pkg::WorldW'(wshift)
             + fbc_pkg::WorldW'($signed(cfg_i.rows[cmd_i.sel][63:48]));
    nsum     = NsW'(n_q[0]) + NsW'(n_q[1]) + NsW'(n_q[2]);
    front_d  = (cnt_q >= fbc_pkg::CountW'(3)) &&
               (cfg_i.persp ? (!acc_q[AccW-1] && (|acc_q)) : (!nsum[NsW-1] && (|nsum)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      last_q <= 1'b0;
      act_q  <= ACC_HOLD;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      act_q <= act_d;
      unique case (cmd_i.op)
        fbc_pkg::OP_LOAD: begin
          last_q <= last_vertex_i;
          if (full) ovf_q <= 1'b1;
        end
        fbc_pkg::OP_WB: begin
          sum_q[cmd_i.sel] <= sum_q[cmd_i.sel] + fbc_pkg::SumW'(world);
          if (cmd_i.sel == 2'd2) cnt_q <= cnt_q + fbc_pkg::CountW'(1);
        end
        fbc_pkg::OP_DECIDE: begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          for (int i = 0; i < 3; i++) sum_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (act_q)
      ACC_LOAD:  acc_q <= prod_ext;
      ACC_ADD:   acc_q <= acc_q + prod_ext;
      ACC_SUB:   acc_q <= acc_q - prod_ext;
      ACC_ADDHI: acc_q <= acc_q + (prod_ext <<< LoW);
      default:   ;
    endcase
    unique case (cmd_i.op)
      fbc_pkg::OP_LOAD: begin
        vtx_q[0] <= vertex_x_i;
        vtx_q[1] <= vertex_y_i;
        vtx_q[2] <= vertex_z_i;
      end
      fbc_pkg::OP_WB: begin
        if (cnt_q < fbc_pkg::CountW'(3)) fw_q[cnt_q[1:0]][cmd_i.sel] <= world;
      end
      fbc_pkg::OP_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EdgeW'(fw_q[1][i]) - EdgeW'(fw_q[0][i]);
          e2_q[i] <= EdgeW'(fw_q[2][i]) - EdgeW'(fw_q[0][i]);
        end
      end
      fbc_pkg::OP_NWB: n_q[cmd_i.sel] <= $signed(acc_q[NormW-1:0]);
      fbc_pkg::OP_VWB: view_q[cmd_i.sel] <= $signed(acc_q[ViewW-1:0]);
      fbc_pkg::OP_DECIDE: begin
        front_q <= front_d;
        long_q  <= ovf_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/face_backface_cull.sv =====
// Top level of the streaming back-face culling block.
//
// Channel   Dir  Handshake        Payload
// vtx_i     in   valid / ready    vertex_x, vertex_y, vertex_z, last_vertex
// res_o     out  valid / ready    front_facing, face_too_long
// APB       in   psel / penable   paddr, pwdata, prdata (registers at 8*i)
//
// A vertex within the size bound is accepted, then the nine products of the
// transform run on the single 33x33 multiplier.
// A vertex past the bound is accepted and not transformed.
// A last vertex adds steps for edges, normal, view vector and dot product.
// Reset needs no clearing pass; a waiting result stalls only the verdict step.
module face_backface_cull #(
  parameter int unsigned MAX_FACE_VERTICES = fbc_pkg::MaxFaceVertices
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fbc_pkg::AddrW-1:0] paddr,
  input  logic [fbc_pkg::RegW-1:0]  pwdata,
  output logic [fbc_pkg::RegW-1:0]  prdata,
  output logic                      pready,
  fbc_vtx_if.sink                   vtx_i,
  fbc_res_if.source                 res_o
);

  fbc_pkg::cfg_t  cfg;
  fbc_pkg::cmd_t  cmd;
  fbc_pkg::stat_t stat;

  fbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_last_i   (vtx_i.last_vertex),
    .in_ready_o  (vtx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fbc_dp #(
    .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .vertex_x_i      (vtx_i.vertex_x),
    .vertex_y_i      (vtx_i.vertex_y),
    .vertex_z_i      (vtx_i.vertex_z),
    .last_vertex_i   (vtx_i.last_vertex),
    .stat_o          (stat),
    .front_facing_o  (res_o.front_facing),
    .face_too_long_o (res_o.face_too_long)
  );

endmodule
